>>> hdl/i2carb_pkg.sv
// Shared types and codes for the I2C bus request arbiter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package i2carb_pkg;

  localparam int CLIENT_W = 3;
  localparam int ADDR_W   = 10;
  localparam int COUNT_W  = 16;
  localparam int FLAGS_W  = 5;
  localparam int STATUS_W = 3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ISSUED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOSTART   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOHANDOFF = 3'd4;

  typedef struct packed {
    logic                mode;
    logic [CLIENT_W-1:0] client;
    logic [ADDR_W-1:0]   target_address;
    logic [COUNT_W-1:0]  transfer_count;
    logic                read_not_write;
    logic                has_start;
    logic                has_stop;
    logic [FLAGS_W-1:0]  event_flags;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CLIENT_W-1:0] issue_client;
    logic [ADDR_W-1:0]   issue_address;
    logic [COUNT_W-1:0]  issue_count;
    logic                issue_read;
    logic                issue_start;
    logic                issue_stop;
    logic                reconfigure;
    logic                bus_idle;
  } out_item_t;

  // one stored client command
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic               rd;
    logic               start;
    logic               stop;
  } req_rec_t;

  typedef enum logic [1:0] {
    CMD_REQ,
    CMD_EVENT,
    CMD_BADCLIENT
  } cmd_kind_t;

  // classified request travelling from front to back
  typedef struct packed {
    cmd_kind_t           kind;
    logic [CLIENT_W-1:0] client;
    req_rec_t            rec;
    logic                ev_hit;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/i2carb_front.sv
// Front end: takes input requests and classifies them into commands.
// Depends on i2carb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2carb_front #(
  parameter int CLIENTS = 8
) (
  input  wire                  in_valid,
  output logic                 in_ready,
  input  i2carb_pkg::in_item_t in_data,
  output logic                 push_valid,
  input  wire                  push_ready,
  output i2carb_pkg::cmd_t     push_cmd
);
  import i2carb_pkg::*;

  logic bad_client;

  assign bad_client = 32'(in_data.client) >= CLIENTS;

  always_comb begin
    push_cmd.client    = in_data.client;
    push_cmd.rec.addr  = in_data.target_address;
    push_cmd.rec.count = in_data.transfer_count;
    push_cmd.rec.rd    = in_data.read_not_write;
    push_cmd.rec.start = in_data.has_start;
    push_cmd.rec.stop  = in_data.has_stop;
    push_cmd.ev_hit    = in_data.event_flags != '0;
    if (in_data.mode) begin
      push_cmd.kind = CMD_EVENT;
    end else if (bad_client) begin
      push_cmd.kind = CMD_BADCLIENT;
    end else begin
      push_cmd.kind = CMD_REQ;
    end
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

`default_nettype wire

>>> hdl/i2carb_cmdq.sv
// Two-entry command queue between front and back.
// Depends on i2carb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2carb_cmdq (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  i2carb_pkg::cmd_t push_cmd,
  output logic             pop_valid,
  input  wire              pop_ready,
  output i2carb_pkg::cmd_t pop_cmd
);
  import i2carb_pkg::*;

  cmd_t       slots_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/i2carb_back.sv
// Back end: bus ownership, wait queue, stored commands and result register.
// Depends on i2carb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2carb_back #(
  parameter int CLIENTS = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cmd_valid,
  output logic                  cmd_ready,
  input  i2carb_pkg::cmd_t      cmd,
  output logic                  out_valid,
  input  wire                   out_ready,
  output i2carb_pkg::out_item_t out_data
);
  import i2carb_pkg::*;

  localparam int IdxW  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int CntW  = $clog2(CLIENTS + 1);
  localparam int WideW = (IdxW > CLIENT_W) ? IdxW : CLIENT_W;

  typedef enum logic {
    S_RUN,
    S_EV_READ
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic                  owner_valid_r;
  logic                  owner_valid_nxt;
  logic [IdxW-1:0]       owner_id_r;
  logic [IdxW-1:0]       owner_id_nxt;
  logic                  cfg_valid_r;
  logic                  cfg_valid_nxt;
  logic [IdxW-1:0]       cfg_id_r;
  logic [IdxW-1:0]       cfg_id_nxt;
  logic [IdxW-1:0]       head_r;
  logic [IdxW-1:0]       head_nxt;
  logic [CntW-1:0]       fill_r;
  logic [CntW-1:0]       fill_nxt;
  logic [CLIENTS-1:0]    queued_r;
  logic [CLIENTS-1:0]    queued_nxt;
  logic [IdxW-1:0]       wait_fifo_r [CLIENTS];
  logic [CLIENTS-1:0]    stop_bits_r;
  logic [CLIENT_W-1:0]   pend_client_r;
  logic [CLIENT_W-1:0]   pend_client_nxt;
  logic                  pend_reconf_r;
  logic                  pend_reconf_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_item_t             out_r;
  out_item_t             out_nxt;

  req_rec_t              store_mem [CLIENTS];
  req_rec_t              rd_data_r;

  logic [WideW-1:0]      cli_wide;
  logic [IdxW-1:0]       idx;
  logic [IdxW-1:0]       next_cli;
  logic [WideW-1:0]      next_wide;
  logic [CntW:0]         tail_sum;
  logic [IdxW-1:0]       tail;
  logic [IdxW-1:0]       head_inc;
  logic                  slot_free;
  logic                  take;
  logic                  handoff;
  logic                  mem_wr;
  logic                  req_reconf;
  logic                  fifo_push;

  assign cli_wide  = WideW'(cmd.client);
  assign idx       = cli_wide[IdxW-1:0];
  assign next_cli  = wait_fifo_r[head_r];
  assign next_wide = WideW'(next_cli);
  assign tail_sum  = (CntW+1)'(head_r) + (CntW+1)'(fill_r);
  assign head_inc  = (head_r == IdxW'(CLIENTS - 1)) ? '0 : head_r + 1'b1;
  assign slot_free = !out_valid_r || out_ready;
  assign take      = (state_r == S_RUN) && cmd_valid && slot_free;
  assign cmd_ready = take;
  assign mem_wr    = take && (cmd.kind == CMD_REQ);
  assign handoff   = cmd.ev_hit && cfg_valid_r && stop_bits_r[cfg_id_r];
  assign req_reconf = !cfg_valid_r || (cfg_id_r != idx);

  always_comb begin
    if (tail_sum >= (CntW+1)'(CLIENTS)) begin
      tail = IdxW'(tail_sum - (CntW+1)'(CLIENTS));
    end else begin
      tail = tail_sum[IdxW-1:0];
    end
  end

  // command store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      store_mem[idx]   <= cmd.rec;
      stop_bits_r[idx] <= cmd.rec.stop;
    end
    rd_data_r <= store_mem[next_cli];
  end

  always_comb begin
    state_nxt       = state_r;
    owner_valid_nxt = owner_valid_r;
    owner_id_nxt    = owner_id_r;
    cfg_valid_nxt   = cfg_valid_r;
    cfg_id_nxt      = cfg_id_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    queued_nxt      = queued_r;
    pend_client_nxt = pend_client_r;
    pend_reconf_nxt = pend_reconf_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_nxt         = out_r;
    fifo_push       = 1'b0;
    unique case (state_r)
      S_RUN: begin
        if (take) begin
          out_valid_nxt    = 1'b1;
          out_nxt          = '0;
          out_nxt.status   = ST_NOHANDOFF;
          out_nxt.bus_idle = !owner_valid_r;
          unique case (cmd.kind)
            CMD_REQ: begin
              priority if (queued_r[idx]) begin
                out_nxt.status = ST_DUP;
              end else if (!owner_valid_r && !cmd.rec.start) begin
                out_nxt.status = ST_NOSTART;
              end else if (!owner_valid_r || owner_id_r == idx) begin
                owner_valid_nxt       = 1'b1;
                owner_id_nxt          = idx;
                cfg_valid_nxt         = 1'b1;
                cfg_id_nxt            = idx;
                out_nxt.status        = ST_ISSUED;
                out_nxt.issue_client  = cmd.client;
                out_nxt.issue_address = cmd.rec.addr;
                out_nxt.issue_count   = cmd.rec.count;
                out_nxt.issue_read    = cmd.rec.rd;
                out_nxt.issue_start   = cmd.rec.start;
                out_nxt.issue_stop    = cmd.rec.stop;
                out_nxt.reconfigure   = req_reconf;
                out_nxt.bus_idle      = 1'b0;
              end else if (fill_r >= CntW'(CLIENTS)) begin
                out_nxt.status = ST_DUP;
              end else begin
                fifo_push       = 1'b1;
                fill_nxt        = fill_r + 1'b1;
                queued_nxt[idx] = 1'b1;
                out_nxt.status  = ST_QUEUED;
              end
            end
            CMD_EVENT: begin
              if (handoff && fill_r != '0) begin
                // result waits in S_EV_READ for the registered store read
                out_valid_nxt        = 1'b0;
                head_nxt             = head_inc;
                fill_nxt             = fill_r - 1'b1;
                queued_nxt[next_cli] = 1'b0;
                owner_valid_nxt      = 1'b1;
                owner_id_nxt         = next_cli;
                cfg_valid_nxt        = 1'b1;
                cfg_id_nxt           = next_cli;
                pend_client_nxt      = next_wide[CLIENT_W-1:0];
                pend_reconf_nxt      = cfg_id_r != next_cli;
                state_nxt            = S_EV_READ;
              end else if (handoff) begin
                owner_valid_nxt  = 1'b0;
                out_nxt.bus_idle = 1'b1;
              end
            end
            default: begin
              out_nxt.status = ST_NOSTART;
            end
          endcase
        end
      end
      S_EV_READ: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = ST_ISSUED;
          out_nxt.issue_client  = pend_client_r;
          out_nxt.issue_address = rd_data_r.addr;
          out_nxt.issue_count   = rd_data_r.count;
          out_nxt.issue_read    = rd_data_r.rd;
          out_nxt.issue_start   = rd_data_r.start;
          out_nxt.issue_stop    = rd_data_r.stop;
          out_nxt.reconfigure   = pend_reconf_r;
          out_nxt.bus_idle      = 1'b0;
          state_nxt             = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_RUN;
      owner_valid_r <= 1'b0;
      owner_id_r    <= '0;
      cfg_valid_r   <= 1'b0;
      cfg_id_r      <= '0;
      head_r        <= '0;
      fill_r        <= '0;
      queued_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      owner_valid_r <= owner_valid_nxt;
      owner_id_r    <= owner_id_nxt;
      cfg_valid_r   <= cfg_valid_nxt;
      cfg_id_r      <= cfg_id_nxt;
      head_r        <= head_nxt;
      fill_r        <= fill_nxt;
      queued_r      <= queued_nxt;
      pend_client_r <= pend_client_nxt;
      pend_reconf_r <= pend_reconf_nxt;
      out_valid_r   <= out_valid_nxt;
      out_r         <= out_nxt;
      if (fifo_push) begin
        wait_fifo_r[tail] <= idx;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // queue bookkeeping stays consistent with the membership bits
  a_fill_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == 32'(fill_r))
    else $error("wait queue fill disagrees with queued bits");

  a_waiters_need_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != '0) |-> owner_valid_r)
    else $error("clients waiting while bus has no owner");

  a_owner_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
    owner_valid_r |-> !queued_r[owner_id_r])
    else $error("bus owner is also in the wait queue");

  a_handoff_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV_READ && slot_free) |=> (out_valid_r && state_r == S_RUN))
    else $error("handoff result not delivered");

endmodule

`default_nettype wire

>>> hdl/shared_i2c_bus_request_arbiter_top.sv
// Top level of the shared I2C bus request arbiter.
// Depends on i2carb_pkg, i2carb_front, i2carb_cmdq and i2carb_back.
`timescale 1ns / 1ps
`default_nettype none

// Shares one I2C master among up to CLIENTS clients. Each request on the
// in_ channel is either a client command (mode 0) or a bus completion event
// (mode 1); each request yields exactly one result on the out_ channel, in
// order. The front end classifies a request and drops it into a two-entry
// command queue; the back end owns all arbitration state (bus owner,
// configured client, FIFO of waiting clients, per-client stored command)
// and a single output register. A client command goes from the back end
// straight into the output register; an event that hands the bus to a
// waiting client also passes through S_EV_READ, because the waiter's
// stored command comes out of a memory with a registered read port. The
// command queue registers each request on its way to the back end, which
// takes the next command in the same cycle the previous result is taken,
// so with out_ready held high it sustains one request per cycle; a handoff
// event first holds S_EV_READ. No clearing pass is needed after reset.
module shared_i2c_bus_request_arbiter_top #(
  parameter int CLIENTS = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  i2carb_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output i2carb_pkg::out_item_t out_data
);
  import i2carb_pkg::*;

  // front -> queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // queue -> back
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  i2carb_front #(
    .CLIENTS(CLIENTS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  i2carb_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  i2carb_back #(
    .CLIENTS(CLIENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(pop_valid),
    .cmd_ready(pop_ready),
    .cmd      (pop_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
